### hdl/ffsa_pkg.sv
// Shared codes, state type and default sizes for the first-fit segment allocator.
package ffsa_pkg;

    localparam int DEF_MAX_SEGMENTS = 16;
    localparam int DEF_ADDR_BITS    = 32;
    localparam int DEF_OWNER_BITS   = 16;
    localparam logic [31:0] RESET_TOTAL = 32'd65536;

    localparam logic [2:0] CMD_ALLOC   = 3'd0;
    localparam logic [2:0] CMD_FREE    = 3'd1;
    localparam logic [2:0] CMD_COMPACT = 3'd2;
    localparam logic [2:0] CMD_CARVE   = 3'd3;
    localparam logic [2:0] CMD_DUMP    = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
    localparam logic [2:0] ST_NO_MEM    = 3'd2;
    localparam logic [2:0] ST_NO_OWNER  = 3'd3;
    localparam logic [2:0] ST_TAB_FULL  = 3'd4;
    localparam logic [2:0] ST_BAD_HOLE  = 3'd5;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_INIT = 6'b000010,
        S_RD   = 6'b000100,
        S_EV   = 6'b001000,
        S_WX   = 6'b010000,
        S_END  = 6'b100000
    } t_state;

endpackage

### hdl/first_fit_segment_allocator.sv
// Top level: first-fit segment allocator with compaction over a ping-pong segment table.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+----------------------------------------
//  command   | in        | start, busy             | i_cmd, i_owner, i_req_size, i_hole_start
//  config    | in        | i_cfg_valid, o_cfg_ready| i_cfg_data (memory size)
//  result    | out       | o_valid (strobe)        | o_status, o_seg_start, o_seg_size,
//            |           |                         | o_seg_is_free, o_seg_owner, o_last
//
// The table lives in two RAMs; each command that changes it streams the current copy into
// the other. A pass reads the entries in turn and writes any split entries in S_WX;
// allocate takes up to four passes (scan, compact, rescan, copy).
// Size and range errors answer in the cycle after acceptance. Reset and a config write each
// rewrite entry zero in S_INIT, with busy and o_cfg_ready held off meanwhile.
// A config beat takes priority over a command, so busy stays high while one is offered.
// Results are one-cycle strobes; the receiver cannot stall them.
module first_fit_segment_allocator #(
    parameter int MAX_SEGMENTS = ffsa_pkg::DEF_MAX_SEGMENTS,
    parameter int ADDR_BITS    = ffsa_pkg::DEF_ADDR_BITS,
    parameter int OWNER_BITS   = ffsa_pkg::DEF_OWNER_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic [15:0] i_owner,
    input  logic [31:0] i_req_size,
    input  logic [31:0] i_hole_start,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [31:0] o_seg_start,
    output logic [31:0] o_seg_size,
    output logic        o_seg_is_free,
    output logic [15:0] o_seg_owner,
    output logic        o_last
);
    import ffsa_pkg::*;

    localparam int AB = ADDR_BITS;
    localparam int OB = OWNER_BITS;
    localparam int W  = 2 * AB + 1 + OB;
    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [31:0] ADDR_MAX = 32'((64'd1 << AB) - 64'd1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);
    localparam logic [AB-1:0] RST_TOT =
        (RESET_TOTAL > ADDR_MAX) ? AB'(ADDR_MAX) : AB'(RESET_TOTAL);

    // state and control
    t_state          r_state, n_state;
    logic [2:0]      r_op, n_op;
    logic            r_copy, n_copy;
    logic            r_cmp, n_cmp;
    logic            r_pass, n_pass;
    logic            r_sel, n_sel;
    logic [CW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_widx, n_widx;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [AB-1:0]   r_total, n_total;
    logic            r_found, n_found;
    logic [CW-1:0]   r_fidx, n_fidx;
    logic [AB-1:0]   r_fstart, n_fstart;
    logic [AB-1:0]   r_fsize, n_fsize;
    logic            r_ffree, n_ffree;
    logic [OB-1:0]   r_fown, n_fown;
    logic [AB:0]     r_sum, n_sum;
    logic [AB:0]     r_pos, n_pos;
    logic [W-1:0]    r_pend, n_pend;
    logic            r_pend_lf, n_pend_lf;
    logic [W-1:0]    r_q0, n_q0, r_q1, n_q1;
    logic [1:0]      r_qn, n_qn;
    logic [31:0]     r_req, n_req;
    logic [31:0]     r_hst, n_hst;
    logic [OB-1:0]   r_ow, n_ow;
    // result registers
    logic            r_ov, n_ov;
    logic [2:0]      r_ost, n_ost;
    logic [31:0]     r_osa, n_osa, r_osz, n_osz;
    logic            r_ofr, n_ofr;
    logic [15:0]     r_oow, n_oow;
    logic            r_olast, n_olast;

    // memory ports
    logic            wr_en, wr_cur;
    logic [W-1:0]    wr_data;
    logic [W-1:0]    rd0, rd1, rd;
    logic            we0, we1;

    // fields of the entry just read
    logic [AB-1:0]   rd_start, rd_size;
    logic            rd_free;
    logic [OB-1:0]   rd_own;

    // helpers
    logic [32:0]     tot33, req33, hend33;
    logic [AB-1:0]   req_a, hst_a, hsz_a;
    logic [AB:0]     fend, hend;
    logic            frnow, merge;
    logic [1:0]      need;
    logic [AB-1:0]   lead, after;
    logic [31:0]     cfg_v;

    ffsa_ram #(.WIDTH(W), .DEPTH(MAX_SEGMENTS)) u_ram0 (
        .i_clk(i_clk), .i_we(we0), .i_waddr(r_widx[AW-1:0]), .i_wdata(wr_data),
        .i_raddr(r_idx[AW-1:0]), .o_rdata(rd0)
    );
    ffsa_ram #(.WIDTH(W), .DEPTH(MAX_SEGMENTS)) u_ram1 (
        .i_clk(i_clk), .i_we(we1), .i_waddr(r_widx[AW-1:0]), .i_wdata(wr_data),
        .i_raddr(r_idx[AW-1:0]), .o_rdata(rd1)
    );

    // steer writes: init goes to the live copy, passes to the other one
    assign we0 = wr_en && ((wr_cur ? r_sel : !r_sel) == 1'b0);
    assign we1 = wr_en && ((wr_cur ? r_sel : !r_sel) == 1'b1);
    assign rd  = r_sel ? rd1 : rd0;

    assign rd_start = rd[W-1 -: AB];
    assign rd_size  = rd[W-AB-1 -: AB];
    assign rd_free  = rd[OB];
    assign rd_own   = rd[OB-1:0];

    assign tot33  = {1'b0, 32'(r_total)};
    assign req33  = {1'b0, i_req_size};
    assign hend33 = {1'b0, i_hole_start} + {1'b0, i_req_size};
    assign req_a  = AB'(r_req);
    assign hst_a  = AB'(r_hst);
    assign hsz_a  = AB'(r_req);
    assign fend   = {1'b0, r_fstart} + {1'b0, r_fsize};
    assign hend   = {1'b0, hst_a} + {1'b0, hsz_a};
    assign lead   = hst_a - r_fstart;
    assign after  = AB'(fend - hend);
    assign need   = {1'b0, (lead != '0)} + {1'b0, (after != '0)};
    assign frnow  = !rd_free && (rd_own == r_ow);
    assign merge  = (r_idx != '0) && r_pend[OB] && (frnow || (rd_free && r_pend_lf));
    assign cfg_v  = (i_cfg_data > ADDR_MAX) ? ADDR_MAX : i_cfg_data;

    assign busy        = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);

    // sequencer
    always_comb begin
        n_state = r_state;  n_op = r_op;       n_copy = r_copy;   n_cmp = r_cmp;
        n_pass = r_pass;    n_sel = r_sel;     n_idx = r_idx;     n_widx = r_widx;
        n_cnt = r_cnt;      n_total = r_total; n_found = r_found; n_fidx = r_fidx;
        n_fstart = r_fstart; n_fsize = r_fsize; n_ffree = r_ffree; n_fown = r_fown;
        n_sum = r_sum;      n_pos = r_pos;     n_pend = r_pend;   n_pend_lf = r_pend_lf;
        n_q0 = r_q0;        n_q1 = r_q1;       n_qn = r_qn;       n_req = r_req;
        n_hst = r_hst;      n_ow = r_ow;
        n_ov = 1'b0;        n_ost = ST_OK;     n_osa = '0;        n_osz = '0;
        n_ofr = 1'b0;       n_oow = '0;        n_olast = 1'b1;
        wr_en = 1'b0;       wr_cur = 1'b0;     wr_data = '0;

        case (r_state)
            S_IDLE: begin
                n_idx = '0; n_widx = '0; n_found = 1'b0; n_sum = '0; n_pos = '0;
                n_pass = 1'b0; n_cmp = 1'b0; n_copy = 1'b0;
                n_req = i_req_size; n_hst = i_hole_start; n_ow = OB'(i_owner);
                n_op = i_cmd;
                if (i_cfg_valid) begin
                    n_total = (cfg_v == '0) ? AB'(1) : AB'(cfg_v);
                    n_state = S_INIT;
                end else if (start) begin
                    case (i_cmd)
                        CMD_ALLOC: begin
                            if (i_req_size == '0 || req33 > tot33) begin
                                n_ov = 1'b1; n_ost = ST_BAD_SIZE;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        CMD_FREE: begin
                            n_copy = 1'b1; n_state = S_RD;
                        end
                        CMD_COMPACT: begin
                            n_copy = 1'b1; n_cmp = 1'b1; n_state = S_RD;
                        end
                        CMD_CARVE: begin
                            if (i_req_size == '0 || {1'b0, i_hole_start} >= tot33
                                || hend33 > tot33) begin
                                n_ov = 1'b1; n_ost = ST_BAD_HOLE;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        CMD_DUMP: n_state = S_RD;
                        default: ;
                    endcase
                end
            end
            S_INIT: begin
                // rewrite entry zero as one reserved segment
                wr_en = 1'b1; wr_cur = 1'b1;
                wr_data = {{AB{1'b0}}, r_total, 1'b0, {OB{1'b0}}};
                n_cnt = CW'(1);
                n_state = S_IDLE;
            end
            S_RD: begin
                n_state = (r_idx == r_cnt) ? S_END : S_EV;
            end
            S_EV: begin
                n_idx = r_idx + CW'(1);
                n_state = S_RD;
                if (r_copy && r_cmp) begin
                    // slide used entries down
                    if (!rd_free) begin
                        wr_en = 1'b1;
                        wr_data = {AB'(r_pos), rd_size, 1'b0, rd_own};
                        n_widx = r_widx + CW'(1);
                        n_pos = r_pos + {1'b0, rd_size};
                    end
                end else if (r_copy && r_op == CMD_FREE) begin
                    // release and merge through a held entry
                    if (frnow) n_found = 1'b1;
                    if (merge) begin
                        n_pend = {r_pend[W-1 -: AB], r_pend[W-AB-1 -: AB] + rd_size,
                                  1'b1, {OB{1'b0}}};
                        n_pend_lf = frnow;
                    end else begin
                        if (r_idx != '0) begin
                            wr_en = 1'b1; wr_data = r_pend;
                            n_widx = r_widx + CW'(1);
                        end
                        n_pend = frnow ? {rd_start, rd_size, 1'b1, {OB{1'b0}}} : rd;
                        n_pend_lf = frnow;
                    end
                end else if (r_copy) begin
                    // copy with a split at the chosen entry
                    wr_en = 1'b1;
                    n_widx = r_widx + CW'(1);
                    wr_data = rd;
                    if (r_idx == r_fidx) begin
                        if (r_op == CMD_ALLOC) begin
                            wr_data = {r_fstart, req_a, 1'b0, r_ow};
                            if (r_fsize != req_a) begin
                                n_q0 = {r_fstart + req_a, r_fsize - req_a, 1'b1, {OB{1'b0}}};
                                n_qn = 2'd1; n_state = S_WX;
                            end
                        end else begin
                            n_q1 = {AB'(hend), after, 1'b0, {OB{1'b0}}};
                            if (lead != '0) begin
                                wr_data = {r_fstart, lead, 1'b0, {OB{1'b0}}};
                                n_q0 = {hst_a, hsz_a, 1'b1, {OB{1'b0}}};
                                n_qn = (after != '0) ? 2'd2 : 2'd1;
                                n_state = S_WX;
                            end else begin
                                wr_data = {hst_a, hsz_a, 1'b1, {OB{1'b0}}};
                                n_q0 = {AB'(hend), after, 1'b0, {OB{1'b0}}};
                                n_qn = (after != '0) ? 2'd1 : 2'd0;
                                if (after != '0) n_state = S_WX;
                            end
                        end
                    end
                end else if (r_op == CMD_DUMP) begin
                    n_ov = 1'b1; n_osa = 32'(rd_start); n_osz = 32'(rd_size);
                    n_ofr = rd_free; n_oow = 16'(rd_own);
                    n_olast = (r_idx + CW'(1) == r_cnt);
                end else if (r_op == CMD_ALLOC) begin
                    // first fit and free total
                    if (rd_free) n_sum = r_sum + {1'b0, rd_size};
                    if (!r_found && rd_free && rd_size >= req_a) begin
                        n_found = 1'b1; n_fidx = r_idx;
                        n_fstart = rd_start; n_fsize = rd_size;
                    end
                end else begin
                    // carve: find the segment holding the hole start
                    if (!r_found && hst_a >= rd_start
                        && {1'b0, hst_a} < {1'b0, rd_start} + {1'b0, rd_size}) begin
                        n_found = 1'b1; n_fidx = r_idx; n_fstart = rd_start;
                        n_fsize = rd_size; n_ffree = rd_free; n_fown = rd_own;
                    end
                end
            end
            S_WX: begin
                wr_en = 1'b1; wr_data = r_q0;
                n_widx = r_widx + CW'(1);
                n_q0 = r_q1;
                n_qn = r_qn - 2'd1;
                if (r_qn == 2'd1) n_state = S_RD;
            end
            S_END: begin
                n_state = S_IDLE;
                n_idx = '0; n_widx = '0;
                if (r_copy && r_cmp) begin
                    n_sel = !r_sel;
                    if ({1'b0, r_total} > r_pos && r_widx < CNT_MAX) begin
                        wr_en = 1'b1;
                        wr_data = {AB'(r_pos), AB'({1'b0, r_total} - r_pos), 1'b1, {OB{1'b0}}};
                        n_cnt = r_widx + CW'(1);
                        n_osa = 32'(r_pos);
                        n_osz = 32'(AB'({1'b0, r_total} - r_pos));
                    end else begin
                        n_cnt = r_widx;
                    end
                    if (r_op == CMD_ALLOC) begin
                        // rescan the compacted table
                        n_osa = '0; n_osz = '0;
                        n_copy = 1'b0; n_cmp = 1'b0; n_pass = 1'b1;
                        n_found = 1'b0; n_sum = '0; n_state = S_RD;
                    end else begin
                        n_ov = 1'b1;
                    end
                end else if (r_copy && r_op == CMD_FREE) begin
                    n_sel = !r_sel;
                    wr_en = (r_cnt != '0); wr_data = r_pend;
                    n_cnt = (r_cnt != '0) ? r_widx + CW'(1) : r_widx;
                    n_ov = 1'b1;
                    n_ost = r_found ? ST_OK : ST_NO_OWNER;
                end else if (r_copy) begin
                    n_sel = !r_sel; n_cnt = r_widx; n_ov = 1'b1;
                    if (r_op == CMD_ALLOC) begin
                        n_osa = 32'(r_fstart); n_osz = r_req; n_oow = 16'(r_ow);
                    end else begin
                        n_osa = r_hst; n_osz = r_req;
                    end
                end else if (r_op == CMD_DUMP) begin
                    if (r_cnt == '0) n_ov = 1'b1;
                end else if (r_op == CMD_ALLOC) begin
                    if (r_found) begin
                        if (r_fsize != req_a && r_cnt >= CNT_MAX) begin
                            n_ov = 1'b1; n_ost = ST_TAB_FULL;
                        end else begin
                            n_copy = 1'b1; n_state = S_RD;
                        end
                    end else if (r_sum < {1'b0, req_a} || r_pass) begin
                        n_ov = 1'b1; n_ost = ST_NO_MEM;
                    end else begin
                        n_copy = 1'b1; n_cmp = 1'b1; n_pos = '0; n_state = S_RD;
                    end
                end else begin
                    if (!r_found || r_ffree || r_fown != '0 || hend > fend) begin
                        n_ov = 1'b1; n_ost = ST_BAD_HOLE;
                    end else if ({1'b0, r_cnt} + (CW+1)'(need) > {1'b0, CNT_MAX}) begin
                        n_ov = 1'b1; n_ost = ST_TAB_FULL;
                    end else begin
                        n_copy = 1'b1; n_qn = '0; n_state = S_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_op    <= CMD_ALLOC;
            r_copy  <= 1'b0;
            r_cmp   <= 1'b0;
            r_pass  <= 1'b0;
            r_sel   <= 1'b0;
            r_idx   <= '0;
            r_widx  <= '0;
            r_cnt   <= CW'(1);
            r_total <= RST_TOT;
            r_found <= 1'b0;
            r_qn    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_copy  <= n_copy;
            r_cmp   <= n_cmp;
            r_pass  <= n_pass;
            r_sel   <= n_sel;
            r_idx   <= n_idx;
            r_widx  <= n_widx;
            r_cnt   <= n_cnt;
            r_total <= n_total;
            r_found <= n_found;
            r_qn    <= n_qn;
            r_ov    <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_fidx <= n_fidx;   r_fstart <= n_fstart; r_fsize <= n_fsize;
        r_ffree <= n_ffree; r_fown <= n_fown;     r_sum <= n_sum;
        r_pos <= n_pos;     r_pend <= n_pend;     r_pend_lf <= n_pend_lf;
        r_q0 <= n_q0;       r_q1 <= n_q1;         r_req <= n_req;
        r_hst <= n_hst;     r_ow <= n_ow;
        r_ost <= n_ost;     r_osa <= n_osa;       r_osz <= n_osz;
        r_ofr <= n_ofr;     r_oow <= n_oow;       r_olast <= n_olast;
    end

    assign o_valid       = r_ov;
    assign o_status      = r_ost;
    assign o_seg_start   = r_osa;
    assign o_seg_size    = r_osz;
    assign o_seg_is_free = r_ofr;
    assign o_seg_owner   = r_oow;
    assign o_last        = r_olast;

    // checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX) else $error("segment count beyond table");
    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> r_widx < CNT_MAX) else $error("table write beyond depth");
    a_unknown_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_cfg_valid && i_cmd > CMD_DUMP) |=> !o_valid)
        else $error("result for unknown command");
    a_cfg_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> (busy && r_state == S_INIT))
        else $error("config write did not rebuild table");
endmodule

### hdl/ffsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### bench/tb_first_fit_segment_allocator.sv
// Self-checking testbench for the first-fit segment allocator with compaction.
`timescale 1ns / 1ps

module tb_first_fit_segment_allocator;
    import ffsa_pkg::*;

    localparam int NSEG = 16;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] seg_start;
        logic [31:0] seg_size;
        logic        seg_is_free;
        logic [15:0] seg_owner;
        logic        last;
    } t_beat;

    typedef struct {
        logic [2:0]  cmd;
        logic [15:0] owner;
        logic [31:0] req_size;
        logic [31:0] hole_start;
        bit          typed_in;
        t_beat       want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [2:0]  i_cmd = '0;
    logic [15:0] i_owner = '0;
    logic [31:0] i_req_size = '0;
    logic [31:0] i_hole_start = '0;
    logic        i_cfg_valid = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        busy, o_cfg_ready, o_valid, o_seg_is_free, o_last;
    logic [2:0]  o_status;
    logic [31:0] o_seg_start, o_seg_size;
    logic [15:0] o_seg_owner;

    first_fit_segment_allocator dut (.*);

    always #2 i_clk = ~i_clk;

    // model copy of the segment table
    logic [31:0] mem_total;
    logic [31:0] tab_start [NSEG];
    logic [31:0] tab_size  [NSEG];
    bit          tab_free  [NSEG];
    logic [15:0] tab_owner [NSEG];
    int          tab_count;

    t_beat results_due[$];
    int    n_errors = 0;
    int    sender_idle = 0;

    function automatic t_beat mk_beat(logic [2:0] st, logic [31:0] a, logic [31:0] s,
                                      bit fr, logic [15:0] ow, bit lst);
        t_beat b;
        b.status = st; b.seg_start = a; b.seg_size = s;
        b.seg_is_free = fr; b.seg_owner = ow; b.last = lst;
        return b;
    endfunction

    task automatic reinit_table(logic [31:0] total);
        mem_total = (total == 0) ? 32'd1 : total;
        tab_start[0] = '0; tab_size[0] = mem_total; tab_free[0] = 0; tab_owner[0] = '0;
        tab_count = 1;
    endtask

    task automatic move_entry(int d, int s);
        tab_start[d] = tab_start[s]; tab_size[d] = tab_size[s];
        tab_free[d] = tab_free[s]; tab_owner[d] = tab_owner[s];
    endtask

    task automatic insert_entry(int idx, logic [31:0] st, logic [31:0] sz, bit fr,
                                logic [15:0] ow);
        for (int i = tab_count; i > idx; i--) move_entry(i, i - 1);
        tab_start[idx] = st; tab_size[idx] = sz; tab_free[idx] = fr; tab_owner[idx] = ow;
        tab_count++;
    endtask

    task automatic remove_entry(int idx);
        for (int i = idx; i + 1 < tab_count; i++) move_entry(i, i + 1);
        tab_count--;
    endtask

    // slide used segments down; returns the free tail size
    task automatic squeeze_table(output longint tail);
        int k;
        longint pos;
        k = 0; pos = 0; tail = 0;
        for (int i = 0; i < tab_count; i++) begin
            if (!tab_free[i]) begin
                move_entry(k, i);
                tab_start[k] = pos[31:0];
                pos += tab_size[k];
                k++;
            end
        end
        if (longint'(mem_total) > pos && k < NSEG) begin
            tab_start[k] = pos[31:0];
            tab_size[k] = mem_total - pos[31:0];
            tab_free[k] = 1; tab_owner[k] = '0;
            k++;
            tail = longint'(mem_total) - pos;
        end
        tab_count = k;
    endtask

    task automatic predict_alloc(logic [31:0] req, logic [15:0] ow);
        longint sum, tail;
        if (req == 0 || req > mem_total) begin
            results_due.push_back(mk_beat(ST_BAD_SIZE, 0, 0, 0, 0, 1));
            return;
        end
        for (int pass = 0; pass < 2; pass++) begin
            for (int i = 0; i < tab_count; i++) begin
                if (tab_free[i] && tab_size[i] >= req) begin
                    if (tab_size[i] != req) begin
                        if (tab_count >= NSEG) begin
                            results_due.push_back(mk_beat(ST_TAB_FULL, 0, 0, 0, 0, 1));
                            return;
                        end
                        insert_entry(i + 1, tab_start[i] + req, tab_size[i] - req, 1, '0);
                        tab_size[i] = req;
                    end
                    tab_free[i] = 0; tab_owner[i] = ow;
                    results_due.push_back(mk_beat(ST_OK, tab_start[i], req, 0, ow, 1));
                    return;
                end
            end
            if (pass == 0) begin
                sum = 0;
                for (int i = 0; i < tab_count; i++) if (tab_free[i]) sum += tab_size[i];
                if (sum < req) break;
                squeeze_table(tail);
            end
        end
        results_due.push_back(mk_beat(ST_NO_MEM, 0, 0, 0, 0, 1));
    endtask

    task automatic predict_free(logic [15:0] ow);
        bit found;
        found = 0;
        for (int i = 0; i < tab_count; i++) begin
            if (!tab_free[i] && tab_owner[i] == ow) begin
                tab_free[i] = 1; tab_owner[i] = '0; found = 1;
                if (i + 1 < tab_count && tab_free[i + 1]) begin
                    tab_size[i] += tab_size[i + 1];
                    remove_entry(i + 1);
                end
                if (i > 0 && tab_free[i - 1]) begin
                    tab_size[i - 1] += tab_size[i];
                    remove_entry(i);
                    i--;
                end
            end
        end
        results_due.push_back(mk_beat(found ? ST_OK : ST_NO_OWNER, 0, 0, 0, 0, 1));
    endtask

    task automatic predict_carve(longint st, longint sz);
        int j, need;
        longint bs, be, lead, trail;
        if (sz == 0 || st >= mem_total || st + sz > mem_total) begin
            results_due.push_back(mk_beat(ST_BAD_HOLE, 0, 0, 0, 0, 1));
            return;
        end
        for (j = 0; j < tab_count; j++) begin
            bs = tab_start[j]; be = bs + tab_size[j];
            if (st >= bs && st < be) break;
        end
        if (j >= tab_count) begin
            results_due.push_back(mk_beat(ST_BAD_HOLE, 0, 0, 0, 0, 1));
            return;
        end
        bs = tab_start[j]; be = bs + tab_size[j];
        if (tab_free[j] || tab_owner[j] != 0 || st + sz > be) begin
            results_due.push_back(mk_beat(ST_BAD_HOLE, 0, 0, 0, 0, 1));
            return;
        end
        lead = st - bs; trail = be - (st + sz);
        need = int'(lead > 0) + int'(trail > 0);
        if (tab_count + need > NSEG) begin
            results_due.push_back(mk_beat(ST_TAB_FULL, 0, 0, 0, 0, 1));
            return;
        end
        if (lead > 0) begin
            tab_size[j] = lead[31:0];
            insert_entry(j + 1, st[31:0], sz[31:0], 1, '0);
            j++;
        end else begin
            tab_start[j] = st[31:0]; tab_size[j] = sz[31:0];
            tab_free[j] = 1; tab_owner[j] = '0;
        end
        if (trail > 0) insert_entry(j + 1, st[31:0] + sz[31:0], trail[31:0], 0, '0);
        results_due.push_back(mk_beat(ST_OK, st[31:0], sz[31:0], 0, 0, 1));
    endtask

    // expected beats of one accepted command
    task automatic predict_command(logic [2:0] cmd, logic [15:0] ow, logic [31:0] req,
                                   logic [31:0] hst);
        longint tail;
        case (cmd)
            CMD_ALLOC: predict_alloc(req, ow);
            CMD_FREE:  predict_free(ow);
            CMD_COMPACT: begin
                squeeze_table(tail);
                results_due.push_back(mk_beat(ST_OK, tail != 0 ? mem_total - tail[31:0] : 0,
                                              tail[31:0], 0, 0, 1));
            end
            CMD_CARVE: predict_carve(longint'(hst), longint'(req));
            CMD_DUMP: begin
                if (tab_count == 0) results_due.push_back(mk_beat(ST_OK, 0, 0, 0, 0, 1));
                for (int i = 0; i < tab_count; i++)
                    results_due.push_back(mk_beat(ST_OK, tab_start[i], tab_size[i],
                                                  tab_free[i], tab_owner[i],
                                                  i + 1 == tab_count));
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what);
        n_errors++;
        $display("ERROR %0t: %s", $realtime, what);
    endtask

    // check each result beat against the oldest expectation
    always @(posedge i_clk) begin
        t_beat got, want;
        if (i_rst_n && o_valid) begin
            got = mk_beat(o_status, o_seg_start, o_seg_size, o_seg_is_free, o_seg_owner,
                          o_last);
            if (results_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
            end else begin
                want = results_due.pop_front();
                if (got.status != want.status)
                    report_mismatch($sformatf("status %0d want %0d", got.status, want.status));
                if (got.seg_start != want.seg_start)
                    report_mismatch($sformatf("start %h want %h", got.seg_start,
                                              want.seg_start));
                if (got.seg_size != want.seg_size)
                    report_mismatch($sformatf("size %h want %h", got.seg_size, want.seg_size));
                if (got.seg_is_free != want.seg_is_free)
                    report_mismatch("free mark differs");
                if (got.seg_owner != want.seg_owner)
                    report_mismatch($sformatf("owner %h want %h", got.seg_owner,
                                              want.seg_owner));
                if (got.last != want.last)
                    report_mismatch("last mark differs");
            end
        end
    end

    // issue one command beat; the predictor runs when it is accepted
    task automatic send_command(logic [2:0] cmd, logic [15:0] ow, logic [31:0] req,
                                logic [31:0] hst);
        // hold start low between beats
        @(negedge i_clk);
        while (sender_idle != 0 && $urandom_range(99) < sender_idle) @(negedge i_clk);
        start <= 1'b1; i_cmd <= cmd; i_owner <= ow; i_req_size <= req; i_hole_start <= hst;
        do @(posedge i_clk); while (busy);
        predict_command(cmd, ow, req, hst);
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    task automatic drain_results();
        while (results_due.size() != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    task automatic write_total(logic [31:0] v);
        drain_results();
        i_cfg_valid <= 1'b1; i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        reinit_table(v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_command(logic [31:0] span);
        int pick;
        logic [31:0] a, s;
        pick = $urandom_range(99);
        a = $urandom_range(span - 1);
        s = $urandom_range(span / 4 + 1, 1);
        if (pick < 4) s = $urandom;
        if (pick < 2) a = $urandom;
        if (pick < 35)      send_command(CMD_ALLOC, 16'($urandom_range(7)), s, $urandom);
        else if (pick < 55) send_command(CMD_FREE, 16'($urandom_range(7)), $urandom,
                                         $urandom);
        else if (pick < 62) send_command(CMD_COMPACT, 16'($urandom), $urandom, $urandom);
        else if (pick < 85) send_command(CMD_CARVE, 16'($urandom), s, a);
        else if (pick < 96) send_command(CMD_DUMP, 16'($urandom), $urandom, $urandom);
        else if (pick < 98) send_command(3'($urandom_range(7, 5)), 16'($urandom), $urandom,
                                         $urandom);
        else                send_command(CMD_ALLOC, 16'($urandom), $urandom, $urandom);
    endtask

    t_row directed[$];

    task automatic add_row(logic [2:0] c, logic [15:0] ow, logic [31:0] r, logic [31:0] h,
                           bit typed_in = 0, logic [2:0] st = ST_OK);
        t_row row;
        row.cmd = c; row.owner = ow; row.req_size = r; row.hole_start = h;
        row.typed_in = typed_in; row.want = mk_beat(st, 0, 0, 0, 0, 1);
        directed.push_back(row);
    endtask

    initial begin
        reinit_table(RESET_TOTAL);
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: extremes, error codes and each special case
        add_row(CMD_DUMP, 16'hFFFF, '1, '1);
        add_row(CMD_ALLOC, 16'h0001, 32'd0, '0, 1, ST_BAD_SIZE);
        add_row(CMD_ALLOC, 16'h0001, 32'hFFFF_FFFF, '0, 1, ST_BAD_SIZE);
        add_row(CMD_ALLOC, 16'h0001, 32'd16, '0, 1, ST_NO_MEM);
        add_row(CMD_FREE, 16'h0009, '0, '0, 1, ST_NO_OWNER);
        add_row(CMD_CARVE, '0, 32'd0, 32'd0, 1, ST_BAD_HOLE);
        add_row(CMD_CARVE, '0, 32'd1, 32'hFFFF_FFFF, 1, ST_BAD_HOLE);
        add_row(CMD_CARVE, '0, 32'h0001_0000, 32'd1, 1, ST_BAD_HOLE);
        add_row(CMD_CARVE, '0, 32'd256, 32'd0, 0);
        add_row(CMD_CARVE, '0, 32'd256, 32'd1024, 0);
        add_row(CMD_CARVE, '0, 32'd256, 32'd1100, 1, ST_BAD_HOLE);
        add_row(CMD_CARVE, '0, 32'd16, 32'h0000_FFF0, 0);
        add_row(CMD_ALLOC, 16'hFFFF, 32'd256, '0, 0);
        add_row(CMD_ALLOC, 16'h8000, 32'd100, '0, 0);
        add_row(CMD_ALLOC, 16'h0002, 32'd300, '0, 0);
        add_row(CMD_DUMP, '0, '0, '0);
        add_row(CMD_COMPACT, '0, '0, '0);
        add_row(CMD_FREE, 16'h8000, '0, '0);
        add_row(CMD_FREE, 16'h0000, '0, '0);
        add_row(3'd7, 16'hFFFF, '1, '1);
        add_row(CMD_ALLOC, 16'h7FFF, 32'h0001_0000, '0, 0);
        add_row(CMD_COMPACT, '0, '0, '0);
        add_row(CMD_DUMP, '0, '0, '0);
        foreach (directed[i]) begin
            send_command(directed[i].cmd, directed[i].owner, directed[i].req_size,
                         directed[i].hole_start);
            if (directed[i].typed_in && results_due.size() != 0) begin
                results_due.pop_back();
                results_due.push_back(directed[i].want);
            end
        end

        // random phases across register settings and idle mixes
        for (int ph = 0; ph < 5; ph++) begin
            logic [31:0] span;
            case (ph)
                0: span = 32'd1;
                1: span = 32'd64;
                2: span = 32'hFFFF_FFFF;
                3: span = 32'd0;
                default: span = 32'd4096;
            endcase
            write_total(span);
            if (span == 0) span = 1;
            sender_idle = (ph == 1 || ph == 4) ? 78 : (ph == 3 ? 16 : 0);
            for (int n = 0; n < 21; n++) begin
                if (span < 64) begin
                    send_command(n % 2 ? CMD_DUMP : CMD_ALLOC, 16'($urandom), span, 0);
                    send_command(CMD_CARVE, 0, span, 0);
                end else begin
                    // well-formed warm-up: open a hole in the reserved space first
                    if (n == 0) send_command(CMD_CARVE, 0, span - span / 8, span / 16);
                    random_command(span > 32'h10_0000 ? 32'h10_0000 : span);
                end
                if (n == 20) drain_results();
            end
        end

        drain_results();
        if (n_errors == 0) $display("PASS first_fit_segment_allocator");
        else $display("FAIL first_fit_segment_allocator");
        $finish;
    end

    initial begin
        #4ms;
        $display("FAIL first_fit_segment_allocator");
        $finish;
    end

endmodule
